// File: rtl/lctu_pkg.sv
// ----------------------------------------------------------------------------
// lctu_pkg
// Shared types, constants and translation tables for the legacy character
// to UTF-8 unit.
// ----------------------------------------------------------------------------
package lctu_pkg;

  // Charset mode codes; any other code passes through
  localparam logic [1:0] ModePass = 2'd0;
  localparam logic [1:0] ModeCp   = 2'd1;
  localparam logic [1:0] ModeGfx  = 2'd2;

  localparam int unsigned CodeW = 21;
  localparam int unsigned CpW   = 16;

  // UTF-8 length class limits
  localparam logic [CodeW-1:0] Lim1 = 21'h000080;
  localparam logic [CodeW-1:0] Lim2 = 21'h000800;
  localparam logic [CodeW-1:0] Lim3 = 21'h010000;

  // Lead and continuation byte tags
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Cont  = 8'h80;
  localparam logic [7:0] ContMask = 8'h3F;

  // One encoded character: up to four bytes and the index of the last one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } seq_t;

  // Code-page table for codes 0x80-0xFF
  function automatic logic [CpW-1:0] cp_lookup(input logic [6:0] idx);
    logic [CpW-1:0] v;
    case (idx)
      7'h00: v = 16'h00C7; 7'h01: v = 16'h00FC; 7'h02: v = 16'h00E9; 7'h03: v = 16'h00E2;
      7'h04: v = 16'h00E4; 7'h05: v = 16'h00E0; 7'h06: v = 16'h00E5; 7'h07: v = 16'h00E7;
      7'h08: v = 16'h00EA; 7'h09: v = 16'h00EB; 7'h0A: v = 16'h00E8; 7'h0B: v = 16'h00EF;
      7'h0C: v = 16'h00EE; 7'h0D: v = 16'h00EC; 7'h0E: v = 16'h00C4; 7'h0F: v = 16'h00C5;
      7'h10: v = 16'h00C9; 7'h11: v = 16'h00E6; 7'h12: v = 16'h00C6; 7'h13: v = 16'h00F4;
      7'h14: v = 16'h00F6; 7'h15: v = 16'h00F2; 7'h16: v = 16'h00FB; 7'h17: v = 16'h00F9;
      7'h18: v = 16'h00FF; 7'h19: v = 16'h00D6; 7'h1A: v = 16'h00DC; 7'h1B: v = 16'h00A2;
      7'h1C: v = 16'h00A3; 7'h1D: v = 16'h00A5; 7'h1E: v = 16'h20A7; 7'h1F: v = 16'h0192;
      7'h20: v = 16'h00E1; 7'h21: v = 16'h00ED; 7'h22: v = 16'h00F3; 7'h23: v = 16'h00FA;
      7'h24: v = 16'h00F1; 7'h25: v = 16'h00D1; 7'h26: v = 16'h00AA; 7'h27: v = 16'h00BA;
      7'h28: v = 16'h00BF; 7'h29: v = 16'h2310; 7'h2A: v = 16'h00AC; 7'h2B: v = 16'h00BD;
      7'h2C: v = 16'h00BC; 7'h2D: v = 16'h00A1; 7'h2E: v = 16'h00AB; 7'h2F: v = 16'h00BB;
      7'h30: v = 16'h2591; 7'h31: v = 16'h2592; 7'h32: v = 16'h2593; 7'h33: v = 16'h2502;
      7'h34: v = 16'h2524; 7'h35: v = 16'h2561; 7'h36: v = 16'h2562; 7'h37: v = 16'h2556;
      7'h38: v = 16'h2555; 7'h39: v = 16'h2563; 7'h3A: v = 16'h2551; 7'h3B: v = 16'h2557;
      7'h3C: v = 16'h255D; 7'h3D: v = 16'h255C; 7'h3E: v = 16'h255B; 7'h3F: v = 16'h2510;
      7'h40: v = 16'h2514; 7'h41: v = 16'h2534; 7'h42: v = 16'h252C; 7'h43: v = 16'h251C;
      7'h44: v = 16'h2500; 7'h45: v = 16'h253C; 7'h46: v = 16'h255E; 7'h47: v = 16'h255F;
      7'h48: v = 16'h255A; 7'h49: v = 16'h2554; 7'h4A: v = 16'h2569; 7'h4B: v = 16'h2566;
      7'h4C: v = 16'h2560; 7'h4D: v = 16'h2550; 7'h4E: v = 16'h256C; 7'h4F: v = 16'h2567;
      7'h50: v = 16'h2568; 7'h51: v = 16'h2564; 7'h52: v = 16'h2565; 7'h53: v = 16'h2559;
      7'h54: v = 16'h2558; 7'h55: v = 16'h2552; 7'h56: v = 16'h2553; 7'h57: v = 16'h256B;
      7'h58: v = 16'h256A; 7'h59: v = 16'h2518; 7'h5A: v = 16'h250C; 7'h5B: v = 16'h2588;
      7'h5C: v = 16'h2584; 7'h5D: v = 16'h258C; 7'h5E: v = 16'h2590; 7'h5F: v = 16'h2580;
      7'h60: v = 16'h03B1; 7'h61: v = 16'h00DF; 7'h62: v = 16'h0393; 7'h63: v = 16'h03C0;
      7'h64: v = 16'h03A3; 7'h65: v = 16'h03C3; 7'h66: v = 16'h00B5; 7'h67: v = 16'h03C4;
      7'h68: v = 16'h03A6; 7'h69: v = 16'h0398; 7'h6A: v = 16'h03A9; 7'h6B: v = 16'h03B4;
      7'h6C: v = 16'h221E; 7'h6D: v = 16'h03C6; 7'h6E: v = 16'h03B5; 7'h6F: v = 16'h2229;
      7'h70: v = 16'h2261; 7'h71: v = 16'h00B1; 7'h72: v = 16'h2265; 7'h73: v = 16'h2264;
      7'h74: v = 16'h2320; 7'h75: v = 16'h2321; 7'h76: v = 16'h00F7; 7'h77: v = 16'h2248;
      7'h78: v = 16'h00B0; 7'h79: v = 16'h2219; 7'h7A: v = 16'h00B7; 7'h7B: v = 16'h221A;
      7'h7C: v = 16'h207F; 7'h7D: v = 16'h00B2; 7'h7E: v = 16'h25A0; 7'h7F: v = 16'h00A0;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // Line-graphics table for codes 0xE0-0xFF
  function automatic logic [CpW-1:0] gfx_lookup(input logic [4:0] idx);
    logic [CpW-1:0] v;
    case (idx)
      5'h00: v = 16'h25C6; 5'h01: v = 16'h2592; 5'h02: v = 16'h0009; 5'h03: v = 16'h000C;
      5'h04: v = 16'h000D; 5'h05: v = 16'h000A; 5'h06: v = 16'h00B0; 5'h07: v = 16'h00B1;
      5'h08: v = 16'h000A; 5'h09: v = 16'h000B; 5'h0A: v = 16'h2518; 5'h0B: v = 16'h2510;
      5'h0C: v = 16'h250C; 5'h0D: v = 16'h2514; 5'h0E: v = 16'h253C; 5'h0F: v = 16'h00A0;
      5'h10: v = 16'h00A0; 5'h11: v = 16'h2500; 5'h12: v = 16'h00A0; 5'h13: v = 16'h00A0;
      5'h14: v = 16'h251C; 5'h15: v = 16'h2524; 5'h16: v = 16'h2534; 5'h17: v = 16'h252C;
      5'h18: v = 16'h2502; 5'h19: v = 16'h2264; 5'h1A: v = 16'h2265; 5'h1B: v = 16'h03C0;
      5'h1C: v = 16'h2260; 5'h1D: v = 16'h00A3; 5'h1E: v = 16'h00B7; 5'h1F: v = 16'h00A0;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/lctu_encode.sv
// ----------------------------------------------------------------------------
// lctu_encode
// Charset translation and UTF-8 byte formation for one registered code.
// ----------------------------------------------------------------------------
module lctu_encode (
  input  logic [1:0]                   mode_i,
  input  logic [lctu_pkg::CodeW-1:0]   code_i,
  output lctu_pkg::seq_t               seq_o
);

  logic [lctu_pkg::CodeW-1:0] cp;
  logic                       in_cp_range;
  logic                       in_gfx_range;

  // Table ranges: 0x80-0xFF and 0xE0-0xFF
  assign in_cp_range  = (code_i[lctu_pkg::CodeW-1:8] == '0) && code_i[7];
  assign in_gfx_range = (code_i[lctu_pkg::CodeW-1:8] == '0) && (code_i[7:5] == 3'b111);

  // Translation
  always_comb begin
    cp = code_i;
    if ((mode_i == lctu_pkg::ModeCp) && in_cp_range) begin
      cp = {{(lctu_pkg::CodeW-lctu_pkg::CpW){1'b0}}, lctu_pkg::cp_lookup(code_i[6:0])};
    end else if ((mode_i == lctu_pkg::ModeGfx) && in_gfx_range) begin
      cp = {{(lctu_pkg::CodeW-lctu_pkg::CpW){1'b0}}, lctu_pkg::gfx_lookup(code_i[4:0])};
    end
  end

  // Length class and byte split
  always_comb begin
    seq_o = '0;
    if (cp < lctu_pkg::Lim1) begin
      seq_o.bytes[0] = cp[7:0];
      seq_o.last_idx = 2'd0;
    end else if (cp < lctu_pkg::Lim2) begin
      seq_o.bytes[0] = lctu_pkg::Lead2 | {3'b000, cp[10:6]};
      seq_o.bytes[1] = lctu_pkg::Cont | ({2'b00, cp[5:0]} & lctu_pkg::ContMask);
      seq_o.last_idx = 2'd1;
    end else if (cp < lctu_pkg::Lim3) begin
      seq_o.bytes[0] = lctu_pkg::Lead3 | {4'h0, cp[15:12]};
      seq_o.bytes[1] = lctu_pkg::Cont | ({2'b00, cp[11:6]} & lctu_pkg::ContMask);
      seq_o.bytes[2] = lctu_pkg::Cont | ({2'b00, cp[5:0]} & lctu_pkg::ContMask);
      seq_o.last_idx = 2'd2;
    end else begin
      seq_o.bytes[0] = lctu_pkg::Lead4 | {5'b00000, cp[20:18]};
      seq_o.bytes[1] = lctu_pkg::Cont | ({2'b00, cp[17:12]} & lctu_pkg::ContMask);
      seq_o.bytes[2] = lctu_pkg::Cont | ({2'b00, cp[11:6]} & lctu_pkg::ContMask);
      seq_o.bytes[3] = lctu_pkg::Cont | ({2'b00, cp[5:0]} & lctu_pkg::ContMask);
      seq_o.last_idx = 2'd3;
    end
  end

endmodule

// File: rtl/lctu_serial.sv
// ----------------------------------------------------------------------------
// lctu_serial
// Result register holding one encoded character; hands out its bytes one
// transaction at a time on the output channel.
// ----------------------------------------------------------------------------
module lctu_serial (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lctu_pkg::seq_t seq_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_byte_o
);

  logic           valid_q, valid_d;
  logic [1:0]     idx_q, idx_d;
  lctu_pkg::seq_t seq_q;
  logic           out_fire;

  assign out_fire    = valid_q && out_ready_i;
  assign last_byte_o = (idx_q == seq_q.last_idx);
  assign out_byte_o  = seq_q.bytes[idx_q];
  assign out_valid_o = valid_q;

  // Free when empty or when the final byte leaves this cycle
  assign free_o = !valid_q || (out_ready_i && last_byte_o);

  // Byte index and occupancy
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (out_fire) begin
      if (last_byte_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      seq_q <= seq_i;
    end
  end

  // A new character only lands in a free register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("character loaded over one still being sent");

  // A non-final byte is followed by the next byte of the same character
  a_next_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_byte_o) |=> (valid_q && (idx_q == $past(idx_q) + 2'd1)))
    else $error("byte sequence broken");

  // Lead byte of a multi-byte sequence carries the lead tag
  a_lead_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (idx_q == 2'd0) && (seq_q.last_idx != 2'd0)) |-> (out_byte_o[7:6] == 2'b11))
    else $error("lead byte without lead tag");

  // Every later byte is a continuation byte
  a_cont_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (idx_q != 2'd0)) |-> (out_byte_o[7:6] == 2'b10))
    else $error("continuation byte without continuation tag");

endmodule

// File: rtl/legacy_char_to_utf8_unit.sv
// ----------------------------------------------------------------------------
// legacy_char_to_utf8_unit
// Translates a legacy character code by charset mode and emits its UTF-8
// encoding, one byte per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, char_code_i) takes one 21-bit code
//   per transaction. Output channel (out_valid_o/out_ready_i) gives one byte
//   per transaction on out_byte_o, last_byte_o high on the final byte.
//   cfg_we_i writes cfg_wdata_i into the charset mode register (0 pass
//   through, 1 code-page table, 2 line-graphics table, 3 pass through);
//   write it only while the unit is idle.
// Path: an accepted code waits in the input register until the result register
//   is free, then is encoded and loaded there, and its first byte is offered
//   from the result register.
// Throughput: a character of 1 to 4 bytes holds the result register until its
//   last byte is taken; the output port moves one byte per cycle while
//   out_ready_i is high. The next code is encoded and loaded in the cycle its
//   predecessor's last byte is taken, so bytes flow without gaps.
// Reset: clears both valid flags and sets the mode to pass through.
// Stall: with out_ready_i low the current byte holds; one further code waits
//   in the input register, then in_ready_o drops.
// ----------------------------------------------------------------------------
module legacy_char_to_utf8_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lctu_pkg::CodeW-1:0] char_code_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_byte_o
);

  logic [1:0]                 mode_q;
  logic                       in_valid_q;
  logic [lctu_pkg::CodeW-1:0] code_q;
  logic                       ser_free;
  logic                       advance;
  lctu_pkg::seq_t             seq;

  // Charset mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lctu_pkg::ModePass;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Input register: moves on whenever the result register is free
  assign advance    = in_valid_q && ser_free;
  assign in_ready_o = !in_valid_q || ser_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      code_q <= char_code_i;
    end
  end

  // Translation and encoding
  lctu_encode u_encode (
    .mode_i (mode_q),
    .code_i (code_q),
    .seq_o  (seq)
  );

  // Result register and byte serialiser
  lctu_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .seq_i       (seq),
    .free_o      (ser_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the legacy character to UTF-8 unit against its own encoder model.
// Codes are sent under every charset mode. Each accepted code is translated
// and split into its expected bytes, and each byte that leaves the unit is
// compared with the oldest byte still due. Both channels stall in random
// bursts, except during a quiet middle phase and in the two closing phases.
// ----------------------------------------------------------------------------
module testbench;

  // The unused mode value; the unit must pass codes through under it
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned PhaseItems = 60;

  // Code-page map for 0x80-0xFF
  localparam logic [15:0] CP_MAP [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // Line-graphics map for 0xE0-0xFF
  localparam logic [15:0] GFX_MAP [32] = '{
    16'h25C6, 16'h2592, 16'h0009, 16'h000C, 16'h000D, 16'h000A, 16'h00B0, 16'h00B1,
    16'h000A, 16'h000B, 16'h2518, 16'h2510, 16'h250C, 16'h2514, 16'h253C, 16'h00A0,
    16'h00A0, 16'h2500, 16'h00A0, 16'h00A0, 16'h251C, 16'h2524, 16'h2534, 16'h252C,
    16'h2502, 16'h2264, 16'h2265, 16'h03C0, 16'h2260, 16'h00A3, 16'h00B7, 16'h00A0
  };

  // Holds the UTF-8 bytes still owed by the unit, oldest first
  class utf8_scoreboard;
    typedef struct packed {
      logic [7:0] value;
      logic       last;
    } utf8_byte_t;

    utf8_byte_t bytes_due[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction

    function logic [20:0] to_code_point(logic [20:0] code, logic [1:0] mode);
      if (mode == lctu_pkg::ModeCp && code >= 21'h80 && code <= 21'hFF)
        return {5'd0, CP_MAP[code[6:0]]};
      if (mode == lctu_pkg::ModeGfx && code >= 21'hE0 && code <= 21'hFF)
        return {5'd0, GFX_MAP[code[4:0]]};
      return code;
    endfunction

    // Accepted input transaction: queue the bytes of its encoding
    function void note_input(logic [20:0] code, logic [1:0] mode);
      logic [20:0] cp;
      logic [7:0]  seq [4];
      int          n;
      cp = to_code_point(code, mode);
      if (cp < 21'h80) begin
        seq[0] = cp[7:0];
        n = 1;
      end else if (cp < 21'h800) begin
        seq[0] = 8'hC0 | {3'b000, cp[10:6]};
        seq[1] = 8'h80 | {2'b00, cp[5:0]};
        n = 2;
      end else if (cp < 21'h10000) begin
        seq[0] = 8'hE0 | {4'h0, cp[15:12]};
        seq[1] = 8'h80 | {2'b00, cp[11:6]};
        seq[2] = 8'h80 | {2'b00, cp[5:0]};
        n = 3;
      end else begin
        seq[0] = 8'hF0 | {5'b00000, cp[20:18]};
        seq[1] = 8'h80 | {2'b00, cp[17:12]};
        seq[2] = 8'h80 | {2'b00, cp[11:6]};
        seq[3] = 8'h80 | {2'b00, cp[5:0]};
        n = 4;
      end
      for (int k = 0; k < n; k++) bytes_due.push_back('{seq[k], k == n - 1});
    endfunction

    // Accepted output transaction: compare with the oldest byte due
    function void check_result(logic [7:0] value, logic last);
      utf8_byte_t due;
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h last %0b",
                 $time, value, last);
        errors++;
        return;
      end
      due = bytes_due.pop_front();
      if (value !== due.value) begin
        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                 $time, due.value, value);
        errors++;
      end
      if (last !== due.last) begin
        $display("%0t: last_byte mismatch, expected %0b, got %0b",
                 $time, due.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [20:0] char_code_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;

  utf8_scoreboard sb;
  logic [1:0]     mode_now;
  bit             idle_on;
  int unsigned    stall_left;
  int unsigned    cycle_count;

  legacy_char_to_utf8_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Output side: ready drops in random bursts while idling is on
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor both channels in one process: note inputs before checking bytes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(char_code_i, mode_now);
      if (out_valid_o && out_ready_i) sb.check_result(out_byte_o, last_byte_o);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One input transaction, with an optional gap in front of it
  task automatic send_code(input logic [20:0] code);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait for every owed byte to leave
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // Mode register write, only with the unit empty
  task automatic set_mode(input logic [1:0] mode);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    mode_now     = mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random code, biased towards the translated ranges and length classes
  function automatic logic [20:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return 21'($urandom_range(0, 'h7F));
      1, 2:    return 21'($urandom_range('h80, 'hFF));
      3:       return 21'($urandom_range('hE0, 'hFF));
      4:       return 21'($urandom_range('h100, 'h7FF));
      5:       return 21'($urandom_range('h800, 'hFFFF));
      6:       return 21'($urandom_range('h10000, 'h1FFFFF));
      default: return 21'($urandom());
    endcase
  endfunction

  initial begin
    logic [1:0] phase_modes [8];
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = lctu_pkg::ModePass;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    out_ready_i = 1'b0;
    mode_now    = lctu_pkg::ModePass;
    idle_on     = 1'b1;
    stall_left  = 0;
    cycle_count = 0;
    phase_modes = '{lctu_pkg::ModeCp, lctu_pkg::ModeGfx, lctu_pkg::ModePass, ModeSpare,
                    lctu_pkg::ModeCp, lctu_pkg::ModeGfx, lctu_pkg::ModeCp, lctu_pkg::ModeGfx};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Pass through after reset: length class edges, surrogates, top of range
    send_code(21'h000000);
    send_code(21'h00007F);
    send_code(21'h000080);
    send_code(21'h0007FF);
    send_code(21'h000800);
    send_code(21'h00D800);
    send_code(21'h00DFFF);
    send_code(21'h00FFFF);
    send_code(21'h010000);
    send_code(21'h10FFFF);
    send_code(21'h110000);
    send_code(21'h1FFFFF);

    // Code-page edges, including a three-byte entry
    set_mode(lctu_pkg::ModeCp);
    send_code(21'h00007F);
    send_code(21'h000080);
    send_code(21'h00009E);
    send_code(21'h0000FF);
    send_code(21'h000100);

    // Line-graphics edges, including control entries that give one byte
    set_mode(lctu_pkg::ModeGfx);
    send_code(21'h0000DF);
    send_code(21'h0000E0);
    send_code(21'h0000E2);
    send_code(21'h0000FF);

    // Spare mode value behaves as pass through
    set_mode(ModeSpare);
    send_code(21'h000080);
    send_code(21'h0000E0);
    send_code(21'h0000FF);

    // Random phases; a quiet phase in the middle and quiet closing phases
    for (int p = 0; p < 8; p++) begin
      set_mode(phase_modes[p]);
      idle_on = (p != 3) && (p < 6);
      for (int i = 0; i < PhaseItems; i++) send_code(pick_code());
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
